FILE: hw/rtl/atma_pkg.sv
// Package for the axis torque magnitude accumulator.
// Shared types, widths and register indexes; no dependencies.
package atma_pkg;

   localparam int unsigned CoordW   = 32;
   localparam int unsigned DirW     = 16;
   localparam int unsigned SumW     = 48;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned QueueDepth = 2;

   localparam logic [CsrIdxW-1:0] RegOriginX = 3'd0;
   localparam logic [CsrIdxW-1:0] RegOriginY = 3'd1;
   localparam logic [CsrIdxW-1:0] RegOriginZ = 3'd2;
   localparam logic [CsrIdxW-1:0] RegDirX    = 3'd3;
   localparam logic [CsrIdxW-1:0] RegDirY    = 3'd4;
   localparam logic [CsrIdxW-1:0] RegDirZ    = 3'd5;

   localparam logic signed [DirW-1:0] DirZReset = 16'sd16384;

   // lever arm and force handed from front to back
   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic               first;
   } job_type;

   typedef enum logic [2:0] {
      FE_IDLE, FE_DOT, FE_PROJ, FE_LEVER, FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_MUL, BE_MAG, BE_SQR, BE_ROOT, BE_ACC, BE_OUT
   } be_state_type;

   function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
      logic signed [63:0] w;
      begin
         w = v + 64'sd8192;
         return w >>> 14;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      begin
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         else if (v < -64'sd2147483648) return 32'sh80000000;
         else return v[31:0];
      end
   endfunction

endpackage

FILE: hw/rtl/atma_front.sv
// Front end: takes a node beat, forms the lever arm r = d - (d.u)u.
// Depends on atma_pkg.
module atma_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [31:0]      req_pos_x,
   input  logic signed [31:0]      req_pos_y,
   input  logic signed [31:0]      req_pos_z,
   input  logic signed [31:0]      req_force_x,
   input  logic signed [31:0]      req_force_y,
   input  logic signed [31:0]      req_force_z,
   input  logic                    req_first_node,
   input  logic signed [31:0]      org_x,
   input  logic signed [31:0]      org_y,
   input  logic signed [31:0]      org_z,
   input  logic signed [15:0]      dir_x,
   input  logic signed [15:0]      dir_y,
   input  logic signed [15:0]      dir_z,
   output logic                    job_valid,
   input  logic                    job_ready,
   output atma_pkg::job_type       job_data
);

   atma_pkg::fe_state_type state_ff, state_in;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [31:0] fx_ff, fy_ff, fz_ff;
   logic               first_ff;
   logic signed [49:0] px_ff, py_ff, pz_ff;
   logic signed [49:0] px_in, py_in, pz_in;
   logic signed [36:0] proj_ff, proj_in;
   logic signed [63:0] qx_ff, qy_ff, qz_ff;
   logic signed [63:0] qx_in, qy_in, qz_in;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   logic signed [31:0] rx_in, ry_in, rz_in;
   logic signed [63:0] dsum;
   // r registers load on the first push cycle; beat offered from the next
   logic               jv_ff, jv_in;

   assign req_ready = (state_ff == atma_pkg::FE_IDLE);

   always_comb begin
      state_in = state_ff;
      px_in = dx_ff * dir_x;
      py_in = dy_ff * dir_y;
      pz_in = dz_ff * dir_z;
      dsum  = 64'(px_ff) + 64'(py_ff) + 64'(pz_ff);
      proj_in = 37'(atma_pkg::rnd14(dsum));
      qx_in = atma_pkg::rnd14(64'(proj_ff) * 64'(dir_x));
      qy_in = atma_pkg::rnd14(64'(proj_ff) * 64'(dir_y));
      qz_in = atma_pkg::rnd14(64'(proj_ff) * 64'(dir_z));
      rx_in = atma_pkg::sat32(64'(dx_ff) - qx_ff);
      ry_in = atma_pkg::sat32(64'(dy_ff) - qy_ff);
      rz_in = atma_pkg::sat32(64'(dz_ff) - qz_ff);
      unique case (state_ff)
         atma_pkg::FE_IDLE:  if (req_valid) state_in = atma_pkg::FE_DOT;
         atma_pkg::FE_DOT:   state_in = atma_pkg::FE_PROJ;
         atma_pkg::FE_PROJ:  state_in = atma_pkg::FE_LEVER;
         atma_pkg::FE_LEVER: state_in = atma_pkg::FE_PUSH;
         atma_pkg::FE_PUSH:  if (jv_ff && job_ready) state_in = atma_pkg::FE_IDLE;
         default:            state_in = atma_pkg::FE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= atma_pkg::FE_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         dx_ff <= 33'(req_pos_x) - 33'(org_x);
         dy_ff <= 33'(req_pos_y) - 33'(org_y);
         dz_ff <= 33'(req_pos_z) - 33'(org_z);
         fx_ff <= req_force_x;
         fy_ff <= req_force_y;
         fz_ff <= req_force_z;
         first_ff <= req_first_node;
      end
      if (state_ff == atma_pkg::FE_DOT) begin
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      end
      if (state_ff == atma_pkg::FE_PROJ) proj_ff <= proj_in;
      if (state_ff == atma_pkg::FE_LEVER) begin
         qx_ff <= qx_in; qy_ff <= qy_in; qz_ff <= qz_in;
      end
      if (state_ff == atma_pkg::FE_PUSH && !jv_ff) begin
         rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
      end
   end

   // hold PUSH until beat taken
   assign jv_in = (state_ff == atma_pkg::FE_PUSH) && !(jv_ff && job_ready);
   always_ff @(posedge clock) begin
      if (reset) jv_ff <= 1'b0;
      else       jv_ff <= jv_in;
   end

   assign job_valid = (state_ff == atma_pkg::FE_PUSH) && jv_ff;
   assign job_data  = '{rx: rx_ff, ry: ry_ff, rz: rz_ff,
                        fx: fx_ff, fy: fy_ff, fz: fz_ff, first: first_ff};

endmodule

FILE: hw/rtl/atma_queue.sv
// Short job queue between front and back ends.
// Depends on atma_pkg.
module atma_queue #(
   parameter int unsigned Depth = atma_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  atma_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output atma_pkg::job_type out_data
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

   atma_pkg::job_type  mem_ff [Depth];
   logic [PtrW-1:0]    wp_ff, rp_ff;
   logic [PtrW:0]      cnt_ff;
   logic               push, pop;

   assign in_ready  = (cnt_ff != (PtrW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PtrW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == PtrW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

FILE: hw/rtl/atma_back.sv
// Back end: cross product magnitudes, bit-serial square root, saturating sum.
// Depends on atma_pkg.
module atma_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  atma_pkg::job_type     job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [47:0]           rsp_torque_total,
   output logic                  rsp_saturated
);

   localparam logic [47:0] SumMax = '1;

   atma_pkg::be_state_type state_ff, state_in;
   atma_pkg::job_type      job_ff;
   logic [1:0]             ph_ff;
   logic signed [63:0]     pa_ff, pb_ff;
   logic [47:0]            m_ff [3];
   logic [4:0]             s_ff;
   logic [1:0]             sq_ff;
   logic [63:0]            acc_ff, v_ff, root_ff, bit_ff;
   logic [5:0]             it_ff;
   logic [47:0]            sum_ff, len;
   logic                   clip_ff;
   logic                   out_full_ff;
   logic [47:0]            out_total_ff;
   logic                   out_sat_ff;
   logic signed [31:0]     ma, mb, mc, md;
   logic signed [63:0]     t;
   logic [63:0]            tm;
   logic [47:0]            mag;
   logic [47:0]            orall;
   logic [4:0]             s_need;
   logic [1:0]             sq_idx;
   logic [30:0]            vs;
   logic [63:0]            trial;
   logic [47:0]            base;
   logic                   base_clip;

   always_comb begin
      unique case (ph_ff)
         2'd0:    begin ma = job_ff.ry; mb = job_ff.fz; mc = job_ff.rz; md = job_ff.fy; end
         2'd1:    begin ma = job_ff.rz; mb = job_ff.fx; mc = job_ff.rx; md = job_ff.fz; end
         default: begin ma = job_ff.rx; mb = job_ff.fy; mc = job_ff.ry; md = job_ff.fx; end
      endcase
      t   = pa_ff - pb_ff;
      tm  = t[63] ? (64'd0 - t) : t;
      mag = 48'((tm + 64'h8000) >> 16);
      orall = m_ff[0] | m_ff[1] | m_ff[2];
      s_need = 5'd0;
      for (int i = 47; i >= 31; i--) begin
         if (orall[i] && s_need == 5'd0) s_need = 5'(i - 30);
      end
      sq_idx = (sq_ff == 2'd0) ? 2'd0 : sq_ff - 2'd1;
      vs = 31'(m_ff[sq_idx] >> s_ff);
      trial = root_ff + bit_ff;
      len = 48'(root_ff << s_ff);
      base = job_ff.first ? 48'd0 : sum_ff;
      base_clip = job_ff.first ? 1'b0 : clip_ff;
   end

   assign job_ready = (state_ff == atma_pkg::BE_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atma_pkg::BE_IDLE: if (job_valid) state_in = atma_pkg::BE_MUL;
         atma_pkg::BE_MUL:  state_in = atma_pkg::BE_MAG;
         atma_pkg::BE_MAG:  state_in = (ph_ff == 2'd2) ? atma_pkg::BE_SQR : atma_pkg::BE_MUL;
         atma_pkg::BE_SQR:  if (sq_ff == 2'd2) state_in = atma_pkg::BE_ROOT;
         atma_pkg::BE_ROOT: if (it_ff == 6'd32) state_in = atma_pkg::BE_ACC;
         atma_pkg::BE_ACC:  state_in = atma_pkg::BE_OUT;
         atma_pkg::BE_OUT:  if (!out_full_ff || rsp_ready) state_in = atma_pkg::BE_IDLE;
         default:           state_in = atma_pkg::BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atma_pkg::BE_IDLE;
         sum_ff <= '0;
         clip_ff <= 1'b0;
         out_full_ff <= 1'b0;
         out_total_ff <= '0;
         out_sat_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_full_ff && rsp_ready) out_full_ff <= 1'b0;
         if (state_ff == atma_pkg::BE_ACC) begin
            if (len >= SumMax - base) begin
               sum_ff <= SumMax; clip_ff <= 1'b1;
            end else begin
               sum_ff <= base + len; clip_ff <= base_clip;
            end
         end
         if (state_ff == atma_pkg::BE_OUT && (!out_full_ff || rsp_ready)) begin
            out_full_ff <= 1'b1;
            out_total_ff <= sum_ff;
            out_sat_ff <= clip_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         atma_pkg::BE_IDLE: begin
            job_ff <= job_data; ph_ff <= 2'd0;
         end
         atma_pkg::BE_MUL: begin
            pa_ff <= 64'(ma) * 64'(mb);
            pb_ff <= 64'(mc) * 64'(md);
         end
         atma_pkg::BE_MAG: begin
            m_ff[ph_ff] <= mag;
            ph_ff <= ph_ff + 2'd1;
            sq_ff <= 2'd0;
            acc_ff <= '0;
         end
         atma_pkg::BE_SQR: begin
            if (sq_ff == 2'd0) s_ff <= s_need;
            else begin
               acc_ff <= acc_ff + 64'(vs) * 64'(vs);
            end
            sq_ff <= sq_ff + 2'd1;
            if (sq_ff == 2'd2) it_ff <= 6'd0;
         end
         atma_pkg::BE_ROOT: begin
            if (it_ff == 6'd0) begin
               // last square lands here, root steps follow
               v_ff <= acc_ff + 64'(vs) * 64'(vs);
               root_ff <= '0;
               bit_ff <= 64'h4000000000000000;
               it_ff <= 6'd1;
            end else begin
               if (v_ff >= trial) begin
                  v_ff <= v_ff - trial;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               it_ff <= it_ff + 6'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = out_full_ff;
   assign rsp_torque_total = out_total_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

FILE: hw/rtl/axis_torque_magnitude_accumulator_unit.sv
// Top level of the axis torque magnitude accumulator.
// Depends on atma_pkg, atma_front, atma_queue, atma_back.
//
// Usage:
//   req_* channel: one beat per node (position, force, first_node flag),
//   valid/ready. rsp_* channel: one beat per node carrying the running
//   saturating torque sum and the saturated flag.
//   csr_* port: write-only; index 0..2 origin x/y/z, 3..5 direction x/y/z.
//   Write only while the block is idle.
// Datapath:
//   The front end forms the lever arm; the back end works on one node at a
//   time through three serial cross-product multiplies and the 32-step
//   bit-serial square root, and takes no new node before it is done.
//   A two-entry queue decouples the front end from the back end.
// Reset:
//   Sum and flag clear, origin clears, direction resets to +z.
//   A stalled rsp holds its beat in an output register; the back end finishes
//   one more node and waits, the queue fills, then req_ready drops.
module axis_torque_magnitude_accumulator_unit #(
   parameter int unsigned QueueDepth = atma_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_force_x,
   input  logic signed [31:0] req_force_y,
   input  logic signed [31:0] req_force_z,
   input  logic               req_first_node,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [47:0]        rsp_torque_total,
   output logic               rsp_saturated,
   input  logic               csr_write,
   input  logic [atma_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [atma_pkg::CsrDataW-1:0] csr_data
);

   logic signed [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic               fj_valid, fj_ready, bj_valid, bj_ready;
   atma_pkg::job_type  fj_data, bj_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0; org_y_ff <= '0; org_z_ff <= '0;
         dir_x_ff <= '0; dir_y_ff <= '0; dir_z_ff <= atma_pkg::DirZReset;
      end else if (csr_write) begin
         unique case (csr_index)
            atma_pkg::RegOriginX: org_x_ff <= csr_data;
            atma_pkg::RegOriginY: org_y_ff <= csr_data;
            atma_pkg::RegOriginZ: org_z_ff <= csr_data;
            atma_pkg::RegDirX:    dir_x_ff <= csr_data[15:0];
            atma_pkg::RegDirY:    dir_y_ff <= csr_data[15:0];
            atma_pkg::RegDirZ:    dir_z_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   atma_front u_front (
      .clock, .reset, .req_valid, .req_ready,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_force_x, .req_force_y, .req_force_z, .req_first_node,
      .org_x(org_x_ff), .org_y(org_y_ff), .org_z(org_z_ff),
      .dir_x(dir_x_ff), .dir_y(dir_y_ff), .dir_z(dir_z_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   atma_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   atma_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_valid, .rsp_ready, .rsp_torque_total, .rsp_saturated
   );

endmodule

FILE: sim/tb_axis_torque_magnitude_accumulator_unit.sv
// Testbench for axis_torque_magnitude_accumulator_unit: directed table, then random
// nodes; every response beat is checked against an in-bench torque sum predictor.
// Depends on atma_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_axis_torque_magnitude_accumulator_unit;

   localparam logic [47:0] SumMax = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic signed [31:0] px, py, pz, fx, fy, fz;
      logic               first;
      bit                 has_exp;
      logic [47:0]        exp_total;
      logic               exp_sat;
   } node_row_type;

   typedef struct {
      logic [47:0] total;
      logic        sat;
   } sum_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_force_x = '0, req_force_y = '0, req_force_z = '0;
   logic req_first_node = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [47:0] rsp_torque_total;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [atma_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [atma_pkg::CsrDataW-1:0] csr_data = '0;

   logic signed [31:0] org_x, org_y, org_z;
   logic signed [15:0] ax_x, ax_y, ax_z;
   logic [47:0] acc_sum;
   logic        acc_clip;

   sum_beat_type sum_q[$];
   int errors = 0;
   int beats_seen = 0;
   bit send_done = 1'b0;

   always #5 clock = ~clock;

   axis_torque_magnitude_accumulator_unit dut (.*);

   task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
      $display("mismatch beat %0d %s: got %h want %h", beats_seen, what, got, want);
      errors++;
   endtask

   function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
      logic signed [63:0] w;
      w = v + 64'sd8192;
      return w >>> 14;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] cross_abs(input logic signed [31:0] a, b, c, d);
      logic signed [64:0] t;
      logic [64:0] m;
      t = 65'(a) * 65'(b) - 65'(c) * 65'(d);
      m = t[64] ? -t : t;
      return 64'((m + 65'h8000) >> 16);
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic sum_beat_type torque_sum_step(input node_row_type n);
      logic signed [63:0] dx, dy, dz, proj;
      logic signed [31:0] rx, ry, rz;
      logic [63:0] mx, my, mz, vx, vy, vz, len;
      int s;
      sum_beat_type o;
      dx = 64'(n.px) - 64'(org_x);
      dy = 64'(n.py) - 64'(org_y);
      dz = 64'(n.pz) - 64'(org_z);
      proj = round_q14(dx * 64'(ax_x) + dy * 64'(ax_y) + dz * 64'(ax_z));
      rx = clip32(dx - round_q14(proj * 64'(ax_x)));
      ry = clip32(dy - round_q14(proj * 64'(ax_y)));
      rz = clip32(dz - round_q14(proj * 64'(ax_z)));
      mx = cross_abs(ry, n.fz, rz, n.fy);
      my = cross_abs(rz, n.fx, rx, n.fz);
      mz = cross_abs(rx, n.fy, ry, n.fx);
      s = 0;
      while (((mx >> s) | (my >> s) | (mz >> s)) >= (64'd1 << 31)) s++;
      vx = mx >> s;
      vy = my >> s;
      vz = mz >> s;
      len = root64(vx * vx + vy * vy + vz * vz) << s;
      if (n.first) begin
         acc_sum = '0;
         acc_clip = 1'b0;
      end
      if (len >= 64'(SumMax - acc_sum)) begin
         acc_sum = SumMax;
         acc_clip = 1'b1;
      end else begin
         acc_sum = acc_sum + len[47:0];
      end
      o.total = acc_sum;
      o.sat = acc_clip;
      return o;
   endfunction

   task automatic csr_put(input logic [atma_pkg::CsrIdxW-1:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         atma_pkg::RegOriginX: org_x = val;
         atma_pkg::RegOriginY: org_y = val;
         atma_pkg::RegOriginZ: org_z = val;
         atma_pkg::RegDirX:    ax_x = val[15:0];
         atma_pkg::RegDirY:    ax_y = val[15:0];
         atma_pkg::RegDirZ:    ax_z = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (sum_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_node(input node_row_type n);
      sum_beat_type e;
      int gap;
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= n.px;
      req_pos_y <= n.py;
      req_pos_z <= n.pz;
      req_force_x <= n.fx;
      req_force_y <= n.fy;
      req_force_z <= n.fz;
      req_first_node <= n.first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e = torque_sum_step(n);
      if (n.has_exp && e.total != n.exp_total)
         report("table total", e.total, n.exp_total);
      if (n.has_exp && e.sat != n.exp_sat)
         report("table saturated", e.sat, n.exp_sat);
      if (n.has_exp) begin
         e.total = n.exp_total;
         e.sat = n.exp_sat;
      end
      sum_q.push_back(e);
   endtask

   function automatic logic signed [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 8'hff) << 16) - 32'sd8388608;
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
      endcase
   endfunction

   function automatic node_row_type rand_node(input int burst);
      node_row_type n;
      int mode;
      mode = $urandom_range(0, 9);
      mode = (mode < 3) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
      n.px = rand_coord(mode);
      n.py = rand_coord(mode);
      n.pz = rand_coord(mode);
      n.fx = rand_coord($urandom_range(0, 3));
      n.fy = rand_coord($urandom_range(0, 3));
      n.fz = rand_coord($urandom_range(0, 3));
      n.first = (burst == 0) || ($urandom_range(0, 40) == 0);
      n.has_exp = 1'b0;
      return n;
   endfunction

   // response side
   always @(posedge clock) begin
      sum_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (sum_q.size() == 0) begin
            $display("response beat with nothing expected");
            errors++;
         end else begin
            e = sum_q.pop_front();
            if (rsp_torque_total !== e.total) report("torque_total", rsp_torque_total, e.total);
            if (rsp_saturated !== e.sat) report("saturated", rsp_saturated, e.sat);
         end
         beats_seen++;
      end
   end

   initial begin
      int gap;
      @(posedge clock);
      while (!send_done || sum_q.size() != 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      #60ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      node_row_type dir_tab[$];
      node_row_type n;
      int burst;
      org_x = 0; org_y = 0; org_z = 0;
      ax_x = 0; ax_y = 0; ax_z = 16'sd16384;
      acc_sum = '0; acc_clip = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero node gives zero after reset
      dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 48'd0, 1'b0});
      // r = (1,0,0), F = (0,1,0): torque 1.0
      dir_tab.push_back('{32'sh10000, 0, 0, 0, 32'sh10000, 0, 1'b1, 1'b1, 48'h10000, 1'b0});
      // z component removed by the axis
      dir_tab.push_back('{32'sh10000, 0, 32'sh7fffffff, 0, 32'sh10000, 0, 1'b0, 1'b1,
                          48'h20000, 1'b0});
      // extremes
      dir_tab.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                          32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0, 0, 0});
      dir_tab.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000, 1'b0, 1'b0, 0, 0});
      dir_tab.push_back('{-1, -1, -1, -1, -1, -1, 1'b0, 1'b0, 0, 0});
      for (int i = 0; i < 8; i++) begin
         n = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff,
               32'sh7fffffff, 1'b0, 1'b0, 0, 0};
         dir_tab.push_back(n);
      end
      foreach (dir_tab[i]) send_node(dir_tab[i]);
      drain_wait();

      // overflow from lever arm saturation, non-unit and extreme directions
      csr_put(atma_pkg::RegOriginX, 32'h8000_0000);
      csr_put(atma_pkg::RegOriginY, 32'h7fff_ffff);
      csr_put(atma_pkg::RegOriginZ, 32'h0001_0000);
      csr_put(atma_pkg::RegDirX, 16'h4000);
      csr_put(atma_pkg::RegDirY, 16'hc000);
      csr_put(atma_pkg::RegDirZ, 16'h4000);
      csr_put(3'd6, 32'hdead_beef);
      csr_put(3'd7, 32'h1234_5678);
      dir_tab.delete();
      dir_tab.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0, 0, 0});
      dir_tab.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0, 0, 0});
      dir_tab.push_back('{0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1, 1'b0, 0, 0});
      foreach (dir_tab[i]) send_node(dir_tab[i]);
      drain_wait();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               csr_put(atma_pkg::RegOriginX, 0); csr_put(atma_pkg::RegOriginY, 0);
               csr_put(atma_pkg::RegOriginZ, 0);
               csr_put(atma_pkg::RegDirX, 0); csr_put(atma_pkg::RegDirY, 0);
               csr_put(atma_pkg::RegDirZ, 16'h4000);
            end
            1: begin
               csr_put(atma_pkg::RegDirX, 16'hc000); csr_put(atma_pkg::RegDirY, 0);
               csr_put(atma_pkg::RegDirZ, 0);
            end
            2: begin
               csr_put(atma_pkg::RegOriginX, 32'h7fff_ffff);
               csr_put(atma_pkg::RegOriginY, 32'h8000_0000);
               csr_put(atma_pkg::RegOriginZ, 32'h7fff_ffff);
            end
            3: begin
               csr_put(atma_pkg::RegDirX, 16'h0000); csr_put(atma_pkg::RegDirY, 16'h0000);
               csr_put(atma_pkg::RegDirZ, 16'h0000);
            end
            default: begin
               csr_put(atma_pkg::RegOriginX, $urandom);
               csr_put(atma_pkg::RegOriginY, $urandom);
               csr_put(atma_pkg::RegOriginZ, $urandom);
               csr_put(atma_pkg::RegDirX, 32'($urandom_range(0, 32768)) - 16384);
               csr_put(atma_pkg::RegDirY, 32'($urandom_range(0, 32768)) - 16384);
               csr_put(atma_pkg::RegDirZ, $urandom);
            end
         endcase
         burst = 0;
         for (int i = 0; i < 200; i++) begin
            if (burst == 0) burst = $urandom_range(1, 60);
            n = rand_node(i == 0 ? 0 : burst);
            send_node(n);
            burst--;
         end
         drain_wait();
      end

      send_done = 1'b1;
      drain_wait();
      if (errors == 0 && sum_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
